[hw/rtl/hig_pkg.sv]
// Shared constants and controller/datapath interface types for the Halton generator.
package hig_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_PRIME    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 8'd1;

  // Register values after reset.
  localparam logic [31:0] INV_PRIME_RESET    = 32'h8000_0000;
  localparam logic [31:0] START_OFFSET_RESET = 32'h0000_0000;

  // Bound on the multiply loop for reciprocals at least the distance to one.
  localparam int unsigned MAX_ITER = 64;
  localparam int unsigned ITER_W   = $clog2(MAX_ITER + 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take a new request, optionally reload the offset
    logic add_small;  // offset += reciprocal
    logic mul_lo;     // multiply the low chunk of h
    logic mul_hi;     // multiply the high chunk of h
    logic eval;       // assemble the product and test it against e
    logic add_big;    // offset += lasth + h - one
    logic out_load;   // load the output register
  } hig_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic big;        // reciprocal is at least e
    logic cont;       // loop goes on after this evaluation
  } hig_status_t;

endpackage

[hw/rtl/hig_in_if.sv]
// Request channel carrying the restart flag.
interface hig_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

[hw/rtl/hig_out_if.sv]
// Result channel carrying the new sample value.
interface hig_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

[hw/rtl/hig_cfg_if.sv]
// Configuration write channel: register index and write data.
interface hig_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

[hw/rtl/hig_ctrl.sv]
// Sequencing state machine for one advance of the Halton generator.
module hig_ctrl #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hig_pkg::hig_cmd_t    cmd,
  input  hig_pkg::hig_status_t status
);
  import hig_pkg::*;

  // Values wider than 32 bits are multiplied in two chunks.
  localparam bit TWO_CHUNK = (FRAC_BITS > 32);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CHECK   = 3'd1;
  localparam logic [2:0] ST_MUL_LO  = 3'd2;
  localparam logic [2:0] ST_MUL_HI  = 3'd3;
  localparam logic [2:0] ST_EVAL    = 3'd4;
  localparam logic [2:0] ST_ADD_BIG = 3'd5;
  localparam logic [2:0] ST_FINISH  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state, commands and output valid.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.big) begin
          state_nxt = ST_MUL_LO;
        end else begin
          cmd.add_small = 1'b1;
          state_nxt     = ST_FINISH;
        end
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = TWO_CHUNK ? ST_MUL_HI : ST_EVAL;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = status.cont ? ST_MUL_LO : ST_ADD_BIG;
      end
      ST_ADD_BIG: begin
        cmd.add_big = 1'b1;
        state_nxt   = ST_FINISH;
      end
      ST_FINISH: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/hig_dp.sv]
// Datapath: running offset, loop registers, shared multiplier and output register.
module hig_dp #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hig_pkg::hig_cmd_t    cmd,
  output hig_pkg::hig_status_t status,
  input  logic                 restart,
  input  logic [31:0]          inv_prime,
  input  logic [31:0]          start_offset,
  output logic [31:0]          sample_value
);
  import hig_pkg::*;

  localparam int unsigned F      = FRAC_BITS;
  // Q0.32 to Q0.F conversion shifts and the reverse.
  localparam int unsigned UP_IN  = (F >= 32) ? F - 32 : 0;
  localparam int unsigned DN_IN  = (F < 32) ? 32 - F : 0;
  localparam int unsigned UP_OUT = (F < 32) ? 32 - F : 0;
  localparam int unsigned DN_OUT = (F >= 32) ? F - 32 : 0;
  // Shift applied to the low-chunk product.
  localparam int unsigned SH     = (F >= 32) ? 32 : F;
  localparam logic [F:0]  ONE    = (F+1)'(1) << F;

  logic [F-1:0]      off_r, off_nxt;
  logic [F:0]        e_r;
  logic [F-1:0]      h_r;
  logic [F-1:0]      lasth_r;
  logic [ITER_W-1:0] k_r;
  logic              big_r;
  logic [63:0]       m_lo_r;
  logic [63:0]       m_hi_r;
  logic [31:0]       sample_r;

  logic [F-1:0]      inv_f;
  logic [F-1:0]      start_f;
  logic [F-1:0]      off_sel;
  logic [F:0]        e_nxt;
  logic [31:0]       mul_b;
  logic [63:0]       h_ext;
  logic [F-1:0]      prod;
  logic [ITER_W-1:0] k_inc;

  // Format conversion of the configuration registers.
  assign inv_f   = F'((64'(inv_prime) << UP_IN) >> DN_IN);
  assign start_f = F'((64'(start_offset) << UP_IN) >> DN_IN);
  // Multiplier operand: the significant 32 bits of the reciprocal.
  assign mul_b   = (F >= 32) ? inv_prime : 32'(inv_f);

  // Offset for this advance and its distance to one (never zero,
  // since the offset is always below one).
  assign off_sel = restart ? start_f : off_r;
  assign e_nxt   = ONE - {1'b0, off_sel};

  // Product assembly from the registered partial products.
  assign h_ext = 64'(h_r);
  assign prod  = F'((m_lo_r >> SH) + m_hi_r);
  assign k_inc = k_r + ITER_W'(1);

  assign status.big  = big_r;
  assign status.cont = ({1'b0, prod} >= e_r) && (k_inc < ITER_W'(MAX_ITER));

  // Offset update.
  always_comb begin
    off_nxt = off_r;
    if (cmd.load) begin
      off_nxt = off_sel;
    end else if (cmd.add_small) begin
      off_nxt = off_r + inv_f;
    end else if (cmd.add_big) begin
      off_nxt = off_r + lasth_r + h_r;
    end
  end

  // Running offset is the only state that reset clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
    end else begin
      off_r <= off_nxt;
    end
  end

  // Loop registers, multiplier and output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e_r     <= e_nxt;
      big_r   <= ({1'b0, inv_f} >= e_nxt);
      h_r     <= inv_f;
      lasth_r <= inv_f;
      k_r     <= '0;
    end
    if (cmd.mul_lo) begin
      lasth_r <= h_r;
      m_lo_r  <= h_ext[31:0] * mul_b;
      m_hi_r  <= '0;
    end
    if (cmd.mul_hi) begin
      m_hi_r <= h_ext[63:32] * mul_b;
    end
    if (cmd.eval) begin
      h_r <= prod;
      k_r <= k_inc;
    end
    if (cmd.out_load) begin
      sample_r <= 32'((64'(off_r) >> DN_OUT) << UP_OUT);
    end
  end

  assign sample_value = sample_r;

endmodule

[hw/rtl/halton_incremental_generator.sv]
// Top level of the incremental Halton generator: configuration registers and core.
//
//   Channel   Dir   Payload                      Transfer
//   in_chan   in    restart (1)                  valid & ready
//   out_chan  out   sample_value (32, Q0.32)     valid & ready
//   cfg_chan  in    index (8), wdata (32)        valid & ready, always ready
//
// A request whose reciprocal adds directly goes from the check state to the finish
// state; otherwise it runs loop iterations of multiply and evaluate, then the add,
// then the finish (when FRAC_BITS > 32 the one 32x32 multiplier works on h in two
// chunks, low then high). Reset clears the running offset and sets the registers
// to one half and zero. A stalled result holds in the output register; the next
// request is taken meanwhile and waits at its end for the register to free.
module halton_incremental_generator #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  hig_in_if.sink    in_chan,
  hig_out_if.source out_chan,
  hig_cfg_if.sink   cfg_chan
);
  import hig_pkg::*;

  logic [31:0] inv_prime_r;
  logic [31:0] start_offset_r;
  hig_cmd_t    cmd;
  hig_status_t status;

  // Configuration writes are always taken.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_prime_r    <= INV_PRIME_RESET;
      start_offset_r <= START_OFFSET_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_INV_PRIME:    inv_prime_r    <= cfg_chan.wdata;
        CFG_START_OFFSET: start_offset_r <= cfg_chan.wdata;
        default: ;
      endcase
    end
  end

  // Controller.
  hig_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Datapath.
  hig_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .restart      (in_chan.restart),
    .inv_prime    (inv_prime_r),
    .start_offset (start_offset_r),
    .sample_value (out_chan.sample_value)
  );

endmodule

[tb/halton_incremental_generator_tb.sv]
// Testbench for the incremental Halton generator: predicts each sample and checks the stream.
`timescale 1ns / 100ps

module halton_incremental_generator_tb;
  import hig_pkg::*;

  // Predicts the sample sequence from the register values and the running offset.
  class halton_predictor;
    logic [31:0] inv_prime;
    logic [31:0] start_offset;
    logic [31:0] offset;
    logic [31:0] expected_samples[$];
    int unsigned mismatch_count;

    function new();
      inv_prime = INV_PRIME_RESET;
      start_offset = START_OFFSET_RESET;
      offset = '0;
      mismatch_count = 0;
    endfunction

    function void write_reg(input logic [7:0] idx, input logic [31:0] data);
      case (idx)
        CFG_INV_PRIME: begin
          inv_prime = data;
        end
        CFG_START_OFFSET: begin
          start_offset = data;
        end
        default: begin
        end
      endcase
    endfunction

    function int unsigned pending();
      return expected_samples.size();
    endfunction

    // Truncating Q0.32 product.
    function logic [31:0] scale(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] prod;
      prod = 64'(a) * 64'(b);
      return prod[63:32];
    endfunction

    // Advance the sequence once for an accepted request.
    function void note_request(input bit restart);
      logic [32:0] headroom;
      logic [31:0] h;
      logic [31:0] lasth;
      logic [63:0] sum;
      int unsigned steps;
      if (restart) begin
        offset = start_offset;
      end
      headroom = 33'h1_0000_0000 - {1'b0, offset};
      if (headroom == 33'd0) begin
        headroom = 33'd1;
      end
      if ({1'b0, inv_prime} >= headroom) begin
        // Shrink h by the reciprocal until it drops below the headroom, or the
        // iteration bound stops it first.
        h = inv_prime;
        lasth = inv_prime;
        steps = 0;
        do begin
          lasth = h;
          h = scale(h, inv_prime);
          steps++;
        end while ({1'b0, h} >= headroom && steps < MAX_ITER);
        sum = 64'(offset) + 64'(lasth) + 64'(h) - 64'h1_0000_0000;
        offset = sum[31:0];
      end else begin
        offset = offset + inv_prime;
      end
      expected_samples.push_back(offset);
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
    endtask

    task check_sample(input logic [31:0] got);
      logic [31:0] want;
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected sample_value %h", got));
      end else begin
        want = expected_samples.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("sample_value got %h, want %h", got, want));
        end
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  hig_in_if  req_if();
  hig_out_if smp_if();
  hig_cfg_if cfg_if();

  halton_incremental_generator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (smp_if),
    .cfg_chan (cfg_if)
  );

  halton_predictor board = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every sample that leaves the block.
  always @(posedge clk) begin
    if (rst_n && smp_if.valid && smp_if.ready) begin
      board.check_sample(smp_if.sample_value);
    end
  end

  // Sample side: random stalls, with stretches where it is always ready.
  initial begin
    int unsigned stall;
    int unsigned served;
    smp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    served = 0;
    forever begin
      stall = ((served / 40) % 3 == 1) ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        smp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      smp_if.ready <= 1'b1;
      do @(posedge clk); while (!smp_if.valid);
      served++;
    end
  end

  // Send one request, then idle for the given number of cycles.
  task automatic send_request(input bit restart, input int unsigned gap);
    req_if.valid <= 1'b1;
    req_if.restart <= restart;
    do @(posedge clk); while (!req_if.ready);
    board.note_request(restart);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted sample has come back.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Write both registers back to back while the block is idle.
  task automatic configure(input logic [31:0] inv, input logic [31:0] start);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_INV_PRIME;
    cfg_if.wdata <= inv;
    do @(posedge clk); while (!cfg_if.ready);
    board.write_reg(CFG_INV_PRIME, inv);
    cfg_if.index <= CFG_START_OFFSET;
    cfg_if.wdata <= start;
    do @(posedge clk); while (!cfg_if.ready);
    board.write_reg(CFG_START_OFFSET, start);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] inv;
    logic [31:0] start;
    bit quiet;
    req_if.valid <= 1'b0;
    req_if.restart <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.wdata <= '0;
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Base two from the reset values, with a restart in the middle.
    repeat (4) send_request(1'b0, $urandom_range(0, 10));
    send_request(1'b1, $urandom_range(0, 10));
    repeat (3) send_request(1'b0, $urandom_range(0, 10));

    // Largest reciprocal from the top offset: iteration bound and wraparound.
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(1'b1, $urandom_range(0, 10));
    repeat (2) send_request(1'b0, $urandom_range(0, 10));

    // Zero reciprocal leaves the offset where it is.
    configure(32'h0000_0000, 32'h8000_0000);
    send_request(1'b1, $urandom_range(0, 10));
    send_request(1'b0, $urandom_range(0, 10));

    // Smallest nonzero reciprocal against the smallest headroom.
    configure(32'h0000_0001, 32'hFFFF_FFFF);
    send_request(1'b1, $urandom_range(0, 10));
    send_request(1'b0, $urandom_range(0, 10));

    // Base three, then a reciprocal above one half.
    configure(32'h5555_5555, 32'hAAAA_AAAA);
    send_request(1'b1, $urandom_range(0, 10));
    repeat (2) send_request(1'b0, $urandom_range(0, 10));
    configure(32'hC000_0000, 32'h0000_0000);
    send_request(1'b1, $urandom_range(0, 10));
    repeat (2) send_request(1'b0, $urandom_range(0, 10));

    // Random phases over common bases, extremes and arbitrary reciprocals.
    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 7))
        0: inv = 32'h8000_0000;
        1: inv = 32'h5555_5555;
        2: inv = 32'h3333_3333;
        3: inv = 32'h2492_4924;
        4: inv = 32'h1745_D174;
        5: inv = $urandom;
        6: inv = $urandom_range(1, 32'h8000_0000);
        default: begin
          case ($urandom_range(0, 2))
            0: inv = 32'h0000_0000;
            1: inv = 32'h0000_0001;
            default: inv = 32'hFFFF_FFFF;
          endcase
        end
      endcase
      case ($urandom_range(0, 3))
        0: start = 32'h0000_0000;
        1: start = 32'hFFFF_FFFF;
        default: start = $urandom;
      endcase
      configure(inv, start);
      quiet = (phase % 3 == 2);
      for (int i = 0; i < 65; i++) begin
        if ($urandom_range(0, 49) == 0 || (phase == 0 && i == 32)) begin
          drain();
        end
        send_request($urandom_range(0, 7) == 0, quiet ? 0 : $urandom_range(0, 10));
      end
    end

    drain();
    repeat (150) @(posedge clk);
    if (board.pending() != 0) begin
      board.report_mismatch($sformatf("%0d samples never arrived", board.pending()));
    end
    if (board.mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

endmodule
